// ----- hdl/apwa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apwa_pkg
// Shared widths, register indexes, datapath commands and status types for the
// sliding-peak audio gain control.
// ----------------------------------------------------------------------------
package apwa_pkg;

	localparam int MAX_CHANNELS  = 8;
	localparam int LOG_FRAC_BITS = 16;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 15;
	localparam int IDX_W    = 3;
	localparam int CNT_W    = 4;
	localparam int CH_W     = $clog2(MAX_CHANNELS);

	localparam int MAG_W     = 16;
	localparam int FS_W      = 15;
	localparam int EXP_W     = 5;
	localparam int LG_W      = EXP_W + LOG_FRAC_BITS;
	localparam int K_W       = FS_W + LG_W;
	localparam int K_LO_W    = K_W / 2;
	localparam int K_HI_W    = K_W - K_LO_W;
	localparam int D_W       = 16;
	localparam int BM_W      = 4;
	localparam int DEN_W     = D_W + BM_W;
	localparam int NUM_W     = MAG_W + K_W + 2;
	localparam int DIV_W     = DEN_W + LOG_FRAC_BITS + 1;
	localparam int QUO_W     = 17;
	localparam int LOG_CNT_W = $clog2(LOG_FRAC_BITS);

	localparam logic [IDX_W-1:0] REG_ENABLE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_WIDE_SAMPLES  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 3'd3;
	localparam logic [IDX_W-1:0] REG_NOISE_FLOOR   = 3'd4;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_UPDATE,
		CMD_SCAN_INIT,
		CMD_SCAN_READ,
		CMD_ENV_START,
		CMD_ENV_TAKE,
		CMD_NORM,
		CMD_LOG,
		CMD_KMUL,
		CMD_MUL_LO,
		CMD_MUL_HI,
		CMD_DIV_START,
		CMD_STORE,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic scan_req;
		logic scan_last;
		logic div_idle;
		logic norm_done;
		logic log_last;
		logic ch_last;
	} status_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

// ----- hdl/apwa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apwa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module apwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/apwa_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apwa_div
// Restoring divider producing one quotient bit per cycle, with a flag for
// quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module apwa_div #(
	parameter int NW = 54,
	parameter int DW = 37,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          idle,
	output logic [QW-1:0] quot,
	output logic          ovf
);

	localparam int MW = (NW > DW + QW) ? NW : DW + QW;
	localparam int CW = $clog2(QW + 1);

	logic [MW-1:0] rem_q;
	logic [MW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= MW'(num);
			dsh_q  <= MW'(den) << (QW - 1);
			ovf_q  <= MW'(num) >= (MW'(den) << QW);
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign idle = cnt_q == '0;
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule
`default_nettype wire

// ----- hdl/apwa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apwa_datapath
// Configuration registers, peak window with its ring memory, envelope,
// fixed-point log2, per-channel gain and output registers.
// ----------------------------------------------------------------------------
module apwa_datapath #(
	parameter int WINDOW_DEPTH = 16384
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  apwa_pkg::cfg_wr_t                             cfg_wr,
	input  apwa_pkg::cmd_t                                cmd,
	input  logic                                          restart,
	input  apwa_pkg::sample_t [apwa_pkg::MAX_CHANNELS-1:0] samples,
	output apwa_pkg::status_t                             status,
	output apwa_pkg::sample_t [apwa_pkg::MAX_CHANNELS-1:0] outs,
	output logic [15:0]                                   level
);
	import apwa_pkg::*;

	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int SW  = AW + 1;
	localparam int LCW = (SW > CFG_W) ? SW : CFG_W;

	// Division by 100 as a multiply by ceil(2^29 / 100) and a shift; exact
	// for every envelope numerator below 2^22.
	localparam logic [22:0] ENV_RECIP = 23'd5368710;
	localparam int          ENV_SHIFT = 29;

	function automatic logic [MAG_W-1:0] mag_of(input sample_t raw, input logic wide);
		logic [7:0] b;
		b = raw[7:0];
		if (wide) begin
			mag_of = raw[15] ? MAG_W'(~raw + 16'd1) : MAG_W'(raw);
		end else begin
			mag_of = b[7] ? MAG_W'(8'(b - 8'd128)) : MAG_W'(8'(8'd128 - b));
		end
	endfunction

	logic             enable_q;
	logic             wide_q;
	logic [CNT_W-1:0] chan_q;
	logic [CFG_W-1:0] wlen_q;
	logic [CFG_W-1:0] nfloor_q;

	logic [MAG_W-1:0] wm_q;
	logic [AW-1:0]    ms_q;
	logic [AW-1:0]    ws_q;
	logic [15:0]      sl_q;
	logic [SW-1:0]    hw_q;
	logic             scan_req_q;
	logic [AW-1:0]    scan_addr_q;
	logic             sc_valid_s1;
	logic [AW-1:0]    sc_idx_s1;

	sample_t [MAX_CHANNELS-1:0] samp_q;
	sample_t [MAX_CHANNELS-1:0] res_q;
	sample_t [MAX_CHANNELS-1:0] out_q;
	logic [15:0]                level_q;

	logic [31:0]              y_q;
	logic [EXP_W-1:0]         n_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [LOG_CNT_W-1:0]     lcnt_q;
	logic [D_W-1:0]           d_q;
	logic [K_W-1:0]           k_q;
	logic [DEN_W-1:0]         den_q;
	logic [MAG_W+K_LO_W-1:0]  plo_q;
	logic [MAG_W+K_HI_W-1:0]  phi_q;
	logic [CH_W-1:0]          ch_q;
	logic [22:0]              env_num_q;

	logic [CNT_W-1:0] nch;
	logic [SW-1:0]    len;
	logic [FS_W-1:0]  fs;
	logic [BM_W-1:0]  bm1;
	logic [MAG_W-1:0] mags [MAX_CHANNELS];
	logic [MAG_W-1:0] peak;
	logic [AW-1:0]    ws_eff;
	logic [SW-1:0]    ws_inc;
	logic [AW-1:0]    ws_next;
	logic             take_peak;
	logic [AW-1:0]    ms_new;
	logic [MAG_W-1:0] rdata;
	logic [MAG_W-1:0] sc_val;
	logic             clear_now;

	logic [22:0]       env_num;
	logic [45:0]       env_prod;
	logic [NUM_W-1:0]  prod;
	logic [NUM_W-1:0]  scale_num;
	logic [DIV_W-1:0]  scale_den;
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DIV_W-1:0]  div_den;
	logic              div_idle;
	logic [QUO_W-1:0]  div_quot;
	logic              div_ovf;
	logic [15:0]       env;
	logic [D_W-1:0]    d_new;
	logic [63:0]       sq;
	logic [32:0]       t;

	sample_t           cur_raw;
	logic [MAG_W-1:0]  cur_mag;
	logic              cur_neg;
	logic [QUO_W-1:0]  qf;
	logic [15:0]       lim;
	logic [15:0]       qc;
	sample_t           enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wide_q   <= 1'b1;
			chan_q   <= 4'd2;
			wlen_q   <= 15'd5512;
			nfloor_q <= 15'd33;
		end else if (cfg_wr.we) begin
			case (cfg_wr.idx)
				REG_ENABLE:        enable_q <= cfg_wr.data[0];
				REG_WIDE_SAMPLES:  wide_q   <= cfg_wr.data[0];
				REG_CHANNEL_COUNT: chan_q   <= cfg_wr.data[CNT_W-1:0];
				REG_WINDOW_LENGTH: wlen_q   <= cfg_wr.data;
				REG_NOISE_FLOOR:   nfloor_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (chan_q == '0) begin
			nch = CNT_W'(1);
		end else if (chan_q > CNT_W'(MAX_CHANNELS)) begin
			nch = CNT_W'(MAX_CHANNELS);
		end else begin
			nch = chan_q;
		end
		if (wlen_q == '0) begin
			len = SW'(1);
		end else if (LCW'(wlen_q) > LCW'(WINDOW_DEPTH)) begin
			len = SW'(WINDOW_DEPTH);
		end else begin
			len = SW'(wlen_q);
		end
	end

	assign fs  = wide_q ? 15'd32767 : 15'd127;
	assign bm1 = wide_q ? 4'd15 : 4'd7;

	always_comb begin
		peak = '0;
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			mags[j] = mag_of(samp_q[j], wide_q);
			if (CNT_W'(j) < nch && mags[j] > peak) begin
				peak = mags[j];
			end
		end
	end

	assign ws_eff    = (SW'(ws_q) >= len) ? '0 : ws_q;
	assign ws_inc    = SW'(ws_eff) + SW'(1);
	assign ws_next   = (ws_inc == len) ? '0 : ws_inc[AW-1:0];
	assign take_peak = peak >= wm_q;
	assign ms_new    = take_peak ? ws_eff : ms_q;
	assign sc_val    = (SW'(sc_idx_s1) < hw_q) ? rdata : '0;
	assign clear_now = (cmd == CMD_CAPTURE && restart) ||
		(cfg_wr.we && cfg_wr.idx == REG_ENABLE && cfg_wr.data[0]);

	apwa_ram #(
		.WIDTH(MAG_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd == CMD_UPDATE),
		.waddr(ws_eff),
		.wdata(peak),
		.raddr(scan_addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q        <= '0;
			ms_q        <= '0;
			ws_q        <= '0;
			sl_q        <= '0;
			hw_q        <= '0;
			scan_req_q  <= 1'b0;
			sc_valid_s1 <= 1'b0;
		end else begin
			sc_valid_s1 <= cmd == CMD_SCAN_READ;
			if (clear_now) begin
				wm_q <= '0;
				ms_q <= '0;
				ws_q <= '0;
				sl_q <= '0;
				hw_q <= '0;
			end else begin
				case (cmd)
					CMD_UPDATE: begin
						if (take_peak) begin
							wm_q <= peak;
						end
						ms_q       <= ms_new;
						ws_q       <= ws_next;
						scan_req_q <= ws_next == ms_new;
						if (ws_inc > hw_q) begin
							hw_q <= ws_inc;
						end
					end
					CMD_SCAN_INIT: wm_q <= '0;
					CMD_ENV_TAKE:  sl_q <= env;
					default: ;
				endcase
				if (sc_valid_s1 && sc_val > wm_q) begin
					wm_q <= sc_val;
					ms_q <= sc_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_SCAN_INIT: scan_addr_q <= AW'(len - SW'(1));
			CMD_SCAN_READ: scan_addr_q <= scan_addr_q - AW'(1);
			default: ;
		endcase
		sc_idx_s1 <= scan_addr_q;
	end

	assign env_num   = 23'(sl_q) * 23'd99 + 23'(wm_q);
	assign env_prod  = 46'(env_num_q) * 46'(ENV_RECIP);
	assign prod      = (NUM_W'(phi_q) << K_LO_W) + NUM_W'(plo_q);
	assign scale_num = (prod << 1) + (NUM_W'(den_q) << LOG_FRAC_BITS);
	assign scale_den = DIV_W'(den_q) << (LOG_FRAC_BITS + 1);
	assign div_start = cmd == CMD_DIV_START;
	assign div_num   = scale_num;
	assign div_den   = scale_den;

	apwa_div #(
		.NW(NUM_W),
		.DW(DIV_W),
		.QW(QUO_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.idle  (div_idle),
		.quot  (div_quot),
		.ovf   (div_ovf)
	);

	assign env   = env_prod[ENV_SHIFT +: 16];
	assign d_new = (env > {1'b0, nfloor_q}) ? env : {1'b0, nfloor_q};
	assign sq    = 64'(y_q) * 64'(y_q);
	assign t     = sq[63:31];

	assign cur_raw = samp_q[ch_q];
	assign cur_mag = mag_of(cur_raw, wide_q);
	assign cur_neg = wide_q ? cur_raw[15] : !cur_raw[7];

	always_comb begin
		qf  = div_ovf ? '1 : div_quot;
		lim = cur_neg ? 16'(fs) + 16'd1 : 16'(fs);
		qc  = (QUO_W'(lim) < qf) ? lim : qf[15:0];
		if (d_q == '0) begin
			qc = '0;
		end
		if (wide_q) begin
			enc = cur_neg ? 16'(~qc + 16'd1) : qc;
		end else begin
			enc = {8'h00, cur_neg ? 8'(8'd128 - qc[7:0]) : 8'(8'd128 + qc[7:0])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			ch_q   <= '0;
		end else begin
			case (cmd)
				CMD_ENV_TAKE: lcnt_q <= '0;
				CMD_LOG:      lcnt_q <= lcnt_q + LOG_CNT_W'(1);
				CMD_KMUL:     ch_q   <= '0;
				CMD_STORE:    ch_q   <= ch_q + CH_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_CAPTURE: begin
				samp_q <= samples;
				res_q  <= samples;
			end
			CMD_ENV_START: env_num_q <= env_num;
			CMD_ENV_TAKE: begin
				d_q    <= d_new;
				y_q    <= 32'(d_new);
				n_q    <= EXP_W'(31);
				frac_q <= '0;
			end
			CMD_NORM: begin
				if (!y_q[31]) begin
					y_q <= y_q << 1;
					n_q <= n_q - EXP_W'(1);
				end
			end
			CMD_LOG: begin
				y_q    <= t[32] ? t[32:1] : t[31:0];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], t[32]};
			end
			CMD_KMUL: begin
				k_q   <= K_W'(fs) * K_W'({n_q, frac_q});
				den_q <= DEN_W'(d_q) * DEN_W'(bm1);
			end
			CMD_MUL_LO: plo_q <= (MAG_W+K_LO_W)'(cur_mag) * (MAG_W+K_LO_W)'(k_q[K_LO_W-1:0]);
			CMD_MUL_HI: phi_q <= (MAG_W+K_HI_W)'(cur_mag) * (MAG_W+K_HI_W)'(k_q[K_W-1:K_LO_W]);
			CMD_STORE:  res_q[ch_q] <= enc;
			CMD_OUT: begin
				out_q   <= res_q;
				level_q <= sl_q;
			end
			default: ;
		endcase
	end

	assign status.enabled   = enable_q;
	assign status.scan_req  = scan_req_q;
	assign status.scan_last = scan_addr_q == '0;
	assign status.div_idle  = div_idle;
	assign status.norm_done = y_q[31] || d_q == '0;
	assign status.log_last  = lcnt_q == LOG_CNT_W'(LOG_FRAC_BITS - 1);
	assign status.ch_last   = CNT_W'(ch_q) + CNT_W'(1) == nch;

	assign outs  = out_q;
	assign level = level_q;

endmodule
`default_nettype wire

// ----- hdl/apwa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apwa_ctrl
// Frame sequencer: accepts a frame and, if enabled, runs window update, rescan
// if due, envelope, log2 and per-channel scaling; it owns the result valid.
// ----------------------------------------------------------------------------
module apwa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  apwa_pkg::status_t status,
	output apwa_pkg::cmd_t    cmd
);
	import apwa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_UPDATE,
		S_SCAN_CHK,
		S_SCAN_INIT,
		S_SCAN,
		S_SCAN_TAIL,
		S_ENV_START,
		S_ENV_WAIT,
		S_ENV_TAKE,
		S_NORM,
		S_LOG,
		S_KMUL,
		S_MUL_LO,
		S_MUL_HI,
		S_DIV_START,
		S_DIV_WAIT,
		S_STORE,
		S_OUT
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = state_q == S_IDLE && frame_valid;
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		case (state_q)
			S_IDLE:      cmd = accept ? CMD_CAPTURE : CMD_NONE;
			S_UPDATE:    cmd = CMD_UPDATE;
			S_SCAN_INIT: cmd = CMD_SCAN_INIT;
			S_SCAN:      cmd = CMD_SCAN_READ;
			S_ENV_START: cmd = CMD_ENV_START;
			S_ENV_TAKE:  cmd = CMD_ENV_TAKE;
			S_NORM:      cmd = CMD_NORM;
			S_LOG:       cmd = CMD_LOG;
			S_KMUL:      cmd = CMD_KMUL;
			S_MUL_LO:    cmd = CMD_MUL_LO;
			S_MUL_HI:    cmd = CMD_MUL_HI;
			S_DIV_START: cmd = CMD_DIV_START;
			S_STORE:     cmd = CMD_STORE;
			S_OUT:       cmd = out_free ? CMD_OUT : CMD_NONE;
			default:     cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK:     state_q <= status.enabled ? S_UPDATE : S_OUT;
				S_UPDATE:    state_q <= S_SCAN_CHK;
				S_SCAN_CHK:  state_q <= status.scan_req ? S_SCAN_INIT : S_ENV_START;
				S_SCAN_INIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_SCAN_TAIL;
					end
				end
				S_SCAN_TAIL: state_q <= S_ENV_START;
				S_ENV_START: state_q <= S_ENV_WAIT;
				S_ENV_WAIT: begin
					if (status.div_idle) begin
						state_q <= S_ENV_TAKE;
					end
				end
				S_ENV_TAKE:  state_q <= S_NORM;
				S_NORM: begin
					if (status.norm_done) begin
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					if (status.log_last) begin
						state_q <= S_KMUL;
					end
				end
				S_KMUL:      state_q <= S_MUL_LO;
				S_MUL_LO:    state_q <= S_MUL_HI;
				S_MUL_HI:    state_q <= S_DIV_START;
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (status.div_idle) begin
						state_q <= S_STORE;
					end
				end
				S_STORE:     state_q <= status.ch_last ? S_OUT : S_MUL_LO;
				S_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	assign frame_stall  = state_q != S_IDLE;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

// ----- hdl/audio_peak_window_agc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// audio_peak_window_agc
// Sliding-peak automatic gain control for audio frames of up to eight channels.
// ----------------------------------------------------------------------------
// Disabled: the frame passes from the check state straight to the output state.
// Enabled: the result waits on the window update, a window rescan when one is due,
// the envelope, the normalize and log2 loops and, per channel, the multiplies and
// the divider wait. One frame at a time. Reset restores the register defaults and
// empties the window.
module audio_peak_window_agc #(
	parameter int WINDOW_DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic        restart,
	input  logic [15:0] sample_0,
	input  logic [15:0] sample_1,
	input  logic [15:0] sample_2,
	input  logic [15:0] sample_3,
	input  logic [15:0] sample_4,
	input  logic [15:0] sample_5,
	input  logic [15:0] sample_6,
	input  logic [15:0] sample_7,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] out_0,
	output logic [15:0] out_1,
	output logic [15:0] out_2,
	output logic [15:0] out_3,
	output logic [15:0] out_4,
	output logic [15:0] out_5,
	output logic [15:0] out_6,
	output logic [15:0] out_7,
	output logic [15:0] level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import apwa_pkg::*;

	sample_t [MAX_CHANNELS-1:0] samples;
	sample_t [MAX_CHANNELS-1:0] outs;
	status_t                    status;
	cmd_t                       cmd;
	cfg_wr_t                    cfg_wr;

	assign samples = {sample_7, sample_6, sample_5, sample_4,
		sample_3, sample_2, sample_1, sample_0};

	assign cfg_ready   = 1'b1;
	assign cfg_wr.we   = cfg_valid && cfg_ready;
	assign cfg_wr.idx  = cfg_index;
	assign cfg_wr.data = cfg_data;

	apwa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status      (status),
		.cmd         (cmd)
	);

	apwa_datapath #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cmd    (cmd),
		.restart(restart),
		.samples(samples),
		.status (status),
		.outs   (outs),
		.level  (level)
	);

	assign out_0 = outs[0];
	assign out_1 = outs[1];
	assign out_2 = outs[2];
	assign out_3 = outs[3];
	assign out_4 = outs[4];
	assign out_5 = outs[5];
	assign out_6 = outs[6];
	assign out_7 = outs[7];

	// The envelope never exceeds full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> level <= 16'd32768)
		else $error("level above full scale");

	// A frame transfer always makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_stall) |=> frame_stall)
		else $error("block not busy after frame transfer");

	// A new result only appears at the end of frame processing.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(frame_stall))
		else $error("result without frame processing");

endmodule
`default_nettype wire

// ----- tb/audio_peak_window_agc_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_peak_window_agc_tb
// Self-checking bench for the sliding-peak gain control. Frames go in with
// bursty valid, results come out under a varying stall pattern, and a
// scoreboard predicts every frame's output samples and envelope level.
// ----------------------------------------------------------------------------
module audio_peak_window_agc_tb;
	import apwa_pkg::*;

	localparam int RING_SIZE = 16384;
	localparam int LIMIT     = 4000000;

	typedef struct {
		logic [15:0] ch [8];
		logic [15:0] lvl;
	} agc_frame_t;

	class agc_scoreboard;
		logic [15:0] ring [RING_SIZE];
		int unsigned win_max, max_pos, wr_pos, env_level;
		int unsigned en, wide, nch_reg, win_len, floor_lvl;
		agc_frame_t  due [$];
		int          errors;
		int          checked;

		function new();
			errors = 0;
			checked = 0;
			clear();
			en = 0;
			wide = 1;
			nch_reg = 2;
			win_len = 5512;
			floor_lvl = 33;
		endfunction

		function void clear();
			foreach (ring[i]) ring[i] = '0;
			win_max = 0;
			max_pos = 0;
			wr_pos = 0;
			env_level = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [14:0] val);
			case (idx)
				REG_ENABLE: begin
					en = val[0];
					if (en) clear();
				end
				REG_WIDE_SAMPLES:  wide = val[0];
				REG_CHANNEL_COUNT: nch_reg = val[3:0];
				REG_WINDOW_LENGTH: win_len = val;
				REG_NOISE_FLOOR:   floor_lvl = val;
				default: ;
			endcase
		endfunction

		function longint unsigned log2_q(int unsigned x);
			int unsigned n;
			longint unsigned y, frac;
			n = 0;
			frac = 0;
			while ((x >> (n + 1)) != 0) n++;
			y = longint'(x) << (31 - n);
			for (int i = 0; i < LOG_FRAC_BITS; i++) begin
				y = (y * y) >> 31;
				frac = frac << 1;
				if (y >= (64'd1 << 32)) begin
					y = y >> 1;
					frac = frac | 1;
				end
			end
			return (longint'(n) << LOG_FRAC_BITS) | frac;
		endfunction

		function void note_frame(logic rst, logic [15:0] smp [8]);
			agc_frame_t      e;
			int unsigned     nch, len, peak, env, d, fs, bm1, m;
			int              v [8];
			longint unsigned lg, den, num, q;
			longint          r;
			if (rst) clear();
			foreach (smp[k]) e.ch[k] = smp[k];
			if (!en) begin
				e.lvl = env_level[15:0];
				due.push_back(e);
				return;
			end
			nch = (nch_reg == 0) ? 1 : (nch_reg > 8 ? 8 : nch_reg);
			len = (win_len == 0) ? 1 : (win_len > RING_SIZE ? RING_SIZE : win_len);
			if (wr_pos >= len) wr_pos = 0;
			fs = wide ? 32767 : 127;
			bm1 = wide ? 15 : 7;
			peak = 0;
			for (int j = 0; j < nch; j++) begin
				v[j] = wide ? int'($signed(smp[j])) : int'(smp[j][7:0]) - 128;
				m = v[j] < 0 ? -v[j] : v[j];
				if (m > peak) peak = m;
			end
			if (peak >= win_max) begin
				win_max = peak;
				max_pos = wr_pos;
			end
			ring[wr_pos] = peak[15:0];
			wr_pos = (wr_pos + 1) % len;
			if (wr_pos == max_pos) begin
				win_max = 0;
				for (int j = len - 1; j >= 0; j--) begin
					if (ring[j] > win_max) begin
						win_max = ring[j];
						max_pos = j;
					end
				end
			end
			env = (env_level * 99 + win_max) / 100;
			d = env > floor_lvl ? env : floor_lvl;
			lg = 0;
			den = 0;
			if (d != 0) begin
				lg = log2_q(d);
				den = (longint'(d) * bm1) << LOG_FRAC_BITS;
			end
			for (int j = 0; j < nch; j++) begin
				m = v[j] < 0 ? -v[j] : v[j];
				q = 0;
				if (d != 0) begin
					num = longint'(m) * fs * lg;
					q = (2 * num + den) / (2 * den);
				end
				if (v[j] < 0) begin
					if (q > fs + 1) q = fs + 1;
					r = -longint'(q);
				end else begin
					if (q > fs) q = fs;
					r = q;
				end
				e.ch[j] = wide ? 16'((r + 65536) & 'hFFFF) : 16'((r + 128) & 'hFF);
			end
			env_level = env;
			e.lvl = env[15:0];
			due.push_back(e);
		endfunction

		function void check_result(logic [15:0] got [8], logic [15:0] lvl);
			agc_frame_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, level %h", $time, lvl);
				errors++;
				return;
			end
			e = due.pop_front();
			checked++;
			foreach (got[k]) begin
				if (got[k] !== e.ch[k]) begin
					$display("%0t: out_%0d expected %h actual %h", $time, k, e.ch[k], got[k]);
					errors++;
				end
			end
			if (lvl !== e.lvl) begin
				$display("%0t: level expected %h actual %h", $time, e.lvl, lvl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        frame_valid;
	logic        frame_stall;
	logic        restart;
	logic [15:0] smp [8];
	logic        result_valid;
	logic        result_stall;
	logic [15:0] res [8];
	logic [15:0] level;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [14:0] cfg_data;

	agc_scoreboard sb;
	int unsigned   cycles;
	int            burst_left;
	int            stall_mode;
	int            frames_sent;

	audio_peak_window_agc u_top (
		.clk(clk), .arst_n(arst_n),
		.frame_valid(frame_valid), .frame_stall(frame_stall), .restart(restart),
		.sample_0(smp[0]), .sample_1(smp[1]), .sample_2(smp[2]), .sample_3(smp[3]),
		.sample_4(smp[4]), .sample_5(smp[5]), .sample_6(smp[6]), .sample_7(smp[7]),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_0(res[0]), .out_1(res[1]), .out_2(res[2]), .out_3(res[3]),
		.out_4(res[4]), .out_5(res[5]), .out_6(res[6]), .out_7(res[7]),
		.level(level),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(res, level);
		if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [14:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(logic rst, logic [15:0] s [8]);
		frame_valid <= 1'b1;
		restart <= rst;
		foreach (s[k]) smp[k] <= s[k];
		do @(posedge clk); while (frame_stall);
		sb.note_frame(rst, s);
		frames_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		frame_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_sample(bit wide_mode);
		logic [15:0] raw;
		raw = $urandom;
		if ($urandom_range(0, 9) < 7) begin
			if (wide_mode) raw = $signed(raw) >>> $urandom_range(0, 15);
			else raw[7:0] = 8'($signed(raw[7:0] ^ 8'h80) >>> $urandom_range(0, 7)) ^ 8'h80;
		end
		return raw;
	endfunction

	task automatic send_fill(logic rst, logic [15:0] val);
		logic [15:0] s [8];
		foreach (s[k]) s[k] = val;
		send_frame(rst, s);
	endtask

	task automatic random_phase(int count);
		logic [15:0] s [8];
		if ($urandom_range(0, 2) != 0) write_cfg(REG_ENABLE, 15'($urandom_range(0, 6) != 0));
		write_cfg(REG_WIDE_SAMPLES, 15'($urandom_range(0, 1)));
		write_cfg(REG_CHANNEL_COUNT, 15'(($urandom_range(0, 4) == 0) ?
			$urandom_range(0, 15) : $urandom_range(1, 8)));
		write_cfg(REG_WINDOW_LENGTH, 15'(($urandom_range(0, 5) == 0) ?
			$urandom_range(0, 300) : $urandom_range(1, 40)));
		write_cfg(REG_NOISE_FLOOR, 15'(($urandom_range(0, 2) == 0) ?
			$urandom_range(0, 32767) : $urandom_range(2, 300)));
		for (int i = 0; i < count; i++) begin
			foreach (s[k]) s[k] = rand_sample(sb.wide != 0);
			send_frame($urandom_range(0, 40) == 0, s);
		end
		drain();
	endtask

	initial begin
		sb = new();
		cycles = 0;
		frames_sent = 0;
		burst_left = 1;
		stall_mode = 0;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		restart = 1'b0;
		foreach (smp[k]) smp[k] = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fill(1'b0, 16'h8000);
		send_fill(1'b1, 16'h7FFF);
		drain();
		write_cfg(REG_CHANNEL_COUNT, 15'd8);
		write_cfg(REG_WINDOW_LENGTH, 15'd4);
		write_cfg(REG_NOISE_FLOOR, 15'd33);
		write_cfg(REG_ENABLE, 15'd1);
		send_fill(1'b0, 16'h8000);
		send_fill(1'b0, 16'h7FFF);
		send_fill(1'b0, 16'h0000);
		send_fill(1'b0, 16'hFFFF);
		send_fill(1'b0, 16'h0100);
		send_fill(1'b1, 16'h0010);
		drain();
		write_cfg(REG_WIDE_SAMPLES, 15'd0);
		write_cfg(REG_CHANNEL_COUNT, 15'd0);
		send_fill(1'b0, 16'hFF00);
		send_fill(1'b0, 16'h00FF);
		send_fill(1'b0, 16'h5580);
		drain();
		write_cfg(REG_CHANNEL_COUNT, 15'd15);
		write_cfg(REG_WINDOW_LENGTH, 15'd0);
		send_fill(1'b0, 16'hAA01);
		send_fill(1'b0, 16'h0080);
		drain();
		write_cfg(REG_WIDE_SAMPLES, 15'd1);
		write_cfg(REG_WINDOW_LENGTH, 15'd32767);
		write_cfg(REG_NOISE_FLOOR, 15'd0);
		send_fill(1'b1, 16'h0000);
		send_fill(1'b0, 16'h0000);
		send_fill(1'b0, 16'h4000);
		drain();
		write_cfg(REG_NOISE_FLOOR, 15'd32767);
		write_cfg(REG_WINDOW_LENGTH, 15'd16384);
		send_fill(1'b0, 16'h7FFF);
		send_fill(1'b0, 16'hC000);
		drain();

		for (int p = 0; p < 9; p++) random_phase(180);
		write_cfg(REG_ENABLE, 15'd1);
		random_phase(40);

		while (sb.due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d frames over ten register settings, %0d results checked.",
			frames_sent, sb.checked);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
